// ===== rtl/core/rtdq_pkg.sv =====
package rtdq_pkg;

  localparam int RotW   = 16;
  localparam int TrW    = 32;
  localparam int CW     = 19;
  localparam int SsW    = 38;
  localparam int RadW   = SsW + 26;
  localparam int NrmW   = RadW / 2;
  localparam int NumW   = CW + 27;
  localparam int QtW    = NumW;
  localparam int InW    = 9 * RotW + 3 * TrW;
  localparam int OutW   = 4 * RotW + 4 * TrW;
  localparam int SqLat  = NrmW;
  localparam int DivLat = QtW;
  localparam int PipeLat = 2 + SqLat + DivLat + 4;
  localparam logic signed [CW-1:0] OneQ14 = 19'sd16384;

  typedef logic signed [CW-1:0] cvec_t [4];
  typedef logic signed [TrW-1:0] tvec_t [3];

  typedef struct packed {
    logic signed [CW-1:0] c0;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic signed [CW-1:0] c3;
  } cpack_t;

  typedef struct packed {
    logic signed [TrW-1:0] tx;
    logic signed [TrW-1:0] ty;
    logic signed [TrW-1:0] tz;
  } tpack_t;

  function automatic logic signed [RotW-1:0] sat16(input logic signed [QtW:0] v);
    logic signed [QtW:0] hi;
    logic signed [QtW:0] lo;
    begin
      hi = (QtW+1)'(32767);
      lo = -(QtW+1)'(32768);
      if (v > hi) sat16 = 16'sh7fff;
      else if (v < lo) sat16 = 16'sh8000;
      else sat16 = v[RotW-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/rtdq_sqrt.sv =====
module rtdq_sqrt import rtdq_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic [RadW-1:0] rad,
  output logic [NrmW-1:0] root
);
  logic [RadW-1:0] rem_r [SqLat+1];
  logic [NrmW-1:0] res_r [SqLat+1];

  assign rem_r[0] = rad;
  assign res_r[0] = '0;

  for (genvar k = 0; k < SqLat; k++) begin : g_st
    logic [RadW-1:0] bit_v;
    logic [RadW-1:0] trial;
    logic [RadW-1:0] rem_nxt;
    logic [NrmW-1:0] res_nxt;
    logic [RadW-1:0] rem_q;
    logic [NrmW-1:0] res_q;
    always_comb begin
      bit_v = RadW'(1) << (2 * (SqLat - 1 - k));
      trial = RadW'(res_r[k]) << (SqLat - k) | bit_v;
      if (rem_r[k] >= trial) begin
        rem_nxt = rem_r[k] - trial;
        res_nxt = res_r[k] | NrmW'(NrmW'(1) << (SqLat - 1 - k));
      end else begin
        rem_nxt = rem_r[k];
        res_nxt = res_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_nxt;
        res_q <= res_nxt;
      end
    end
    assign rem_r[k+1] = rem_q;
    assign res_r[k+1] = res_q;
  end

  assign root = res_r[SqLat];
endmodule

// ===== rtl/core/rtdq_div.sv =====
module rtdq_div import rtdq_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic signed [CW-1:0] num,
  input  logic [NrmW-1:0] den,
  output logic signed [RotW-1:0] q
);
  logic [NumW-1:0] nm_r [DivLat+1];
  logic [NumW+NrmW-1:0] rm_r [DivLat+1];
  logic [QtW-1:0] qt_r [DivLat+1];
  logic [NrmW-1:0] dn_r [DivLat+1];
  logic sg_r [DivLat+1];

  logic [CW-1:0] mag;
  assign mag = num[CW-1] ? CW'(-num) : CW'(num);

  assign nm_r[0] = {mag, 27'd0};
  assign rm_r[0] = '0;
  assign qt_r[0] = '0;
  assign dn_r[0] = den;
  assign sg_r[0] = num[CW-1];

  for (genvar k = 0; k < DivLat; k++) begin : g_st
    logic [NumW+NrmW-1:0] sh;
    logic [NumW+NrmW-1:0] rm_q;
    logic [QtW-1:0] qt_q;
    logic [NumW-1:0] nm_q;
    logic [NrmW-1:0] dn_q;
    logic sg_q;
    logic ge;
    assign sh = {rm_r[k][NumW+NrmW-2:0], nm_r[k][NumW-1]};
    assign ge = sh >= (NumW+NrmW)'(dn_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        rm_q <= ge ? sh - (NumW+NrmW)'(dn_r[k]) : sh;
        qt_q <= {qt_r[k][QtW-2:0], ge};
        nm_q <= {nm_r[k][NumW-2:0], 1'b0};
        dn_q <= dn_r[k];
        sg_q <= sg_r[k];
      end
    end
    assign rm_r[k+1] = rm_q;
    assign qt_r[k+1] = qt_q;
    assign nm_r[k+1] = nm_q;
    assign dn_r[k+1] = dn_q;
    assign sg_r[k+1] = sg_q;
  end

  logic [QtW:0] rq;
  logic [NumW+NrmW:0] r2;
  logic signed [QtW:0] sq;
  always_comb begin
    r2 = {rm_r[DivLat], 1'b0};
    rq = {1'b0, qt_r[DivLat]} +
         ((QtW+1)'(r2 >= (NumW+NrmW+1)'(dn_r[DivLat])));
    sq = sg_r[DivLat] ? -$signed(rq) : $signed(rq);
    q = sat16(sq);
  end
endmodule

// ===== rtl/core/rigid_transform_to_dual_quaternion.sv =====
// one transform per item, one item per clock while the output is not stalled; fully pipelined
// (square root is one bit per stage, the four divides one quotient bit per stage); the
// pipeline advances whenever the output register is empty or taken, so a stall holds all
// stages. a zero-length quaternion gives the identity rotation.
module rigid_transform_to_dual_quaternion import rtdq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // rot_00..rot_22 (16 each), trans_x, trans_y, trans_z (32 each)
  input  logic [InW-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // real_w, real_x, real_y, real_z (16 each), dual_w, dual_x, dual_y, dual_z (32 each)
  output logic [OutW-1:0] out_tdata
);
  logic en;
  logic [PipeLat-1:0] v_r;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: branch pick and c vector
  logic signed [CW-1:0] m [9];
  tvec_t t_in;
  for (genvar i = 0; i < 9; i++) begin : g_m
    assign m[i] = CW'($signed(in_tdata[i*RotW +: RotW]));
  end
  for (genvar i = 0; i < 3; i++) begin : g_t
    assign t_in[i] = $signed(in_tdata[9*RotW + i*TrW +: TrW]);
  end

  cvec_t c_nxt;
  always_comb begin
    logic signed [CW-1:0] tr;
    logic signed [CW-1:0] a;
    tr = m[0] + m[4] + m[8];
    a = '0;
    if (tr > 0) begin
      c_nxt[0] = OneQ14 + tr;
      c_nxt[1] = m[7] - m[5];
      c_nxt[2] = m[2] - m[6];
      c_nxt[3] = m[3] - m[1];
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      a = OneQ14 + m[0] - m[4] - m[8];
      c_nxt[0] = m[7] - m[5];
      c_nxt[1] = a < 0 ? '0 : a;
      c_nxt[2] = m[1] + m[3];
      c_nxt[3] = m[2] + m[6];
    end else if (m[4] > m[8]) begin
      a = OneQ14 + m[4] - m[0] - m[8];
      c_nxt[0] = m[2] - m[6];
      c_nxt[1] = m[1] + m[3];
      c_nxt[2] = a < 0 ? '0 : a;
      c_nxt[3] = m[5] + m[7];
    end else begin
      a = OneQ14 + m[8] - m[0] - m[4];
      c_nxt[0] = m[3] - m[1];
      c_nxt[1] = m[2] + m[6];
      c_nxt[2] = m[5] + m[7];
      c_nxt[3] = a < 0 ? '0 : a;
    end
  end

  cpack_t c1_r;
  tpack_t t1_r;
  logic [SsW-1:0] sq_r [4];
  cpack_t c2_r;
  tpack_t t2_r;
  logic [SsW-1:0] ss2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= '{c_nxt[0], c_nxt[1], c_nxt[2], c_nxt[3]};
      t1_r <= '{t_in[0], t_in[1], t_in[2]};
      c2_r <= c1_r;
      t2_r <= t1_r;
      ss2_r <= sq_r[0] + sq_r[1] + sq_r[2] + sq_r[3];
    end
  end
  always_comb begin
    sq_r[0] = SsW'(c1_r.c0 * c1_r.c0);
    sq_r[1] = SsW'(c1_r.c1 * c1_r.c1);
    sq_r[2] = SsW'(c1_r.c2 * c1_r.c2);
    sq_r[3] = SsW'(c1_r.c3 * c1_r.c3);
  end

  // square root stages, c and t ride alongside
  logic [NrmW-1:0] nrm;
  rtdq_sqrt u_sqrt (
    .clk(clk), .en(en), .rad({ss2_r, 26'd0}), .root(nrm)
  );
  cpack_t cs_r [SqLat];
  tpack_t ts_r [SqLat];
  always_ff @(posedge clk) begin
    if (en) begin
      cs_r[0] <= c2_r;
      ts_r[0] <= t2_r;
      for (int k = 1; k < SqLat; k++) begin
        cs_r[k] <= cs_r[k-1];
        ts_r[k] <= ts_r[k-1];
      end
    end
  end

  // divides
  logic signed [RotW-1:0] qd [4];
  logic signed [CW-1:0] cn [4];
  assign cn[0] = cs_r[SqLat-1].c0;
  assign cn[1] = cs_r[SqLat-1].c1;
  assign cn[2] = cs_r[SqLat-1].c2;
  assign cn[3] = cs_r[SqLat-1].c3;
  for (genvar i = 0; i < 4; i++) begin : g_div
    rtdq_div u_div (
      .clk(clk), .en(en), .num(cn[i]), .den(nrm), .q(qd[i])
    );
  end
  tpack_t td_r [DivLat];
  logic zd_r [DivLat];
  always_ff @(posedge clk) begin
    if (en) begin
      td_r[0] <= ts_r[SqLat-1];
      zd_r[0] <= nrm == '0;
      for (int k = 1; k < DivLat; k++) begin
        td_r[k] <= td_r[k-1];
        zd_r[k] <= zd_r[k-1];
      end
    end
  end

  // dual part: products, sums, rounding
  logic signed [RotW-1:0] q_r [4];
  tpack_t tq_r;
  logic signed [RotW+TrW-1:0] p_r [12];
  logic signed [RotW-1:0] q2_r [4];
  logic signed [RotW+TrW+2:0] d_r [4];
  logic signed [RotW-1:0] q3_r [4];
  logic signed [RotW-1:0] q4_r [4];
  logic signed [TrW-1:0] o_r [4];

  function automatic logic signed [TrW-1:0] rnd(input logic signed [RotW+TrW+2:0] d);
    logic [RotW+TrW+2:0] mg;
    logic [RotW+TrW+2:0] r;
    logic signed [RotW+TrW+2:0] s;
    begin
      mg = d[RotW+TrW+2] ? -d : d;
      r = (mg + 51'd16384) >> 15;
      s = d[RotW+TrW+2] ? -$signed(r) : $signed(r);
      if (s > 51'sd2147483647) rnd = 32'sh7fffffff;
      else if (s < -51'sd2147483648) rnd = 32'sh80000000;
      else rnd = s[TrW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        q_r[i] <= zd_r[DivLat-1] ? (i == 0 ? RotW'(16384) : '0) : qd[i];
      end
      tq_r <= td_r[DivLat-1];
      p_r[0]  <= tq_r.tx * q_r[1];
      p_r[1]  <= tq_r.ty * q_r[2];
      p_r[2]  <= tq_r.tz * q_r[3];
      p_r[3]  <= tq_r.tx * q_r[0];
      p_r[4]  <= tq_r.ty * q_r[3];
      p_r[5]  <= tq_r.tz * q_r[2];
      p_r[6]  <= tq_r.ty * q_r[0];
      p_r[7]  <= tq_r.tz * q_r[1];
      p_r[8]  <= tq_r.tx * q_r[3];
      p_r[9]  <= tq_r.tz * q_r[0];
      p_r[10] <= tq_r.tx * q_r[2];
      p_r[11] <= tq_r.ty * q_r[1];
      q2_r <= q_r;
      for (int i = 0; i < 4; i++) begin
        if (i == 0)
          d_r[i] <= -(51'(p_r[0]) + 51'(p_r[1]) + 51'(p_r[2]));
        else
          d_r[i] <= 51'(p_r[3*i]) + 51'(p_r[3*i+1]) - 51'(p_r[3*i+2]);
      end
      q3_r <= q2_r;
      for (int i = 0; i < 4; i++) begin
        o_r[i] <= rnd(d_r[i]);
      end
      q4_r <= q3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[PipeLat-2:0], in_tvalid};
  end

  assign out_tvalid = v_r[PipeLat-1];
  assign out_tdata = {o_r[3], o_r[2], o_r[1], o_r[0], q4_r[3], q4_r[2], q4_r[1], q4_r[0]};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0]) else $error("advance");
endmodule
